/* rtl/core/bmc_pkg.sv */
// bmc_pkg: shared types, constants and duty helpers for the button menu controller
// no dependencies
package bmc_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [2:0] PageLast = 3'd5;
  localparam logic [2:0] PageMode = 3'd1;
  localparam logic [2:0] PagePump = 3'd2;
  localparam logic [2:0] PageRoof = 3'd3;
  localparam logic [2:0] PagePumpDuty = 3'd4;
  localparam logic [2:0] PageRoofDuty = 3'd5;

  localparam logic [6:0] DutyMax = 7'd100;

  localparam logic [15:0] DebounceRst = 16'd20;
  localparam logic [15:0] HoldRst = 16'd500;
  localparam logic [6:0] DutyStepRst = 7'd10;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_STEP     = 2'd2,
    REG_NONE     = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ROOF_STOP = 2'd0,
    ROOF_FWD  = 2'd1,
    ROOF_BACK = 2'd2
  } roof_e;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [6:0]  duty_step;
  } cfg_t;

  typedef struct packed {
    logic [2:0] page;
    logic       auto_mode;
    logic       pump_on;
    roof_e      roof;
    logic [6:0] pump_duty;
    logic [6:0] roof_duty;
    logic       changed;
  } res_t;

  function automatic logic [6:0] duty_up(input logic [6:0] duty, input logic [6:0] step);
    logic [7:0] sum;
    sum = {1'b0, duty} + {1'b0, step};
    if (sum > {1'b0, DutyMax}) begin
      return DutyMax;
    end
    return sum[6:0];
  endfunction

  function automatic logic [6:0] duty_down(input logic [6:0] duty, input logic [6:0] step);
    if (duty > step) begin
      return duty - step;
    end
    return 7'd0;
  endfunction

endpackage

/* rtl/core/bmc_debounce.sv */
// bmc_debounce: one button debouncer with press time stamp and held flag
// depends on bmc_pkg
module bmc_debounce (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          upd_i,
  input  logic          eval_i,
  input  logic          level_i,
  input  logic [31:0]   now_i,
  input  bmc_pkg::cfg_t cfg_i,
  output logic          fire_o
);

  logic [31:0] press_time_q, press_time_d;
  logic        held_q, held_d;
  logic [31:0] since;
  logic        long_enough;

  assign since = now_i - press_time_q;
  assign long_enough = since >= {16'd0, cfg_i.debounce_ms};
  assign fire_o = eval_i && !level_i && !held_q && long_enough;

  always_comb begin
    press_time_d = press_time_q;
    held_d = held_q;
    if (upd_i && eval_i) begin
      if (level_i) begin
        held_d = 1'b0;
      end else if (!held_q) begin
        if (long_enough) begin
          held_d = 1'b1;
          press_time_d = now_i;
        end
      end else if (since > {16'd0, cfg_i.hold_ms}) begin
        held_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_time_q <= 32'd0;
      held_q <= 1'b0;
    end else begin
      press_time_q <= press_time_d;
      held_q <= held_d;
    end
  end

endmodule

/* rtl/core/bmc_menu.sv */
// bmc_menu: page, mode and actuator settings, updated from debounced presses
// depends on bmc_pkg
module bmc_menu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          upd_i,
  input  logic          fire_next_i,
  input  logic          fire_up_i,
  input  logic          fire_down_i,
  input  logic [6:0]    duty_step_i,
  output logic          eval_ud_o,
  output bmc_pkg::res_t res_o
);

  logic [2:0]     page_q, page_d;
  logic           mode_q, mode_d;
  logic           pump_q, pump_d;
  bmc_pkg::roof_e roof_q, roof_d;
  logic [6:0]     pduty_q, pduty_d;
  logic [6:0]     rduty_q, rduty_d;
  logic [6:0]     tmp;
  logic           chg;
  logic [2:0]     page_nxt;

  assign page_nxt = !fire_next_i ? page_q
                  : (page_q >= bmc_pkg::PageLast) ? 3'd0 : page_q + 3'd1;

  assign eval_ud_o = (page_nxt == bmc_pkg::PageMode)
                  || (!mode_q && page_nxt >= bmc_pkg::PagePump
                      && page_nxt <= bmc_pkg::PageLast);

  always_comb begin
    page_d = page_nxt;
    mode_d = mode_q;
    pump_d = pump_q;
    roof_d = roof_q;
    pduty_d = pduty_q;
    rduty_d = rduty_q;
    tmp = 7'd0;
    chg = fire_next_i;
    if (page_d == bmc_pkg::PageMode) begin
      if (fire_up_i && !mode_d) begin
        mode_d = 1'b1;
        chg = 1'b1;
      end
      if (fire_down_i && mode_d) begin
        mode_d = 1'b0;
        chg = 1'b1;
      end
    end else if (!mode_q) begin
      unique case (page_d)
        bmc_pkg::PagePump: begin
          if (fire_up_i && !pump_d) begin
            pump_d = 1'b1;
            chg = 1'b1;
          end
          if (fire_down_i && pump_d) begin
            pump_d = 1'b0;
            chg = 1'b1;
          end
        end
        bmc_pkg::PageRoof: begin
          if (fire_up_i && roof_d != bmc_pkg::ROOF_FWD) begin
            roof_d = bmc_pkg::ROOF_FWD;
            chg = 1'b1;
          end
          if (fire_down_i) begin
            roof_d = (roof_d == bmc_pkg::ROOF_BACK) ? bmc_pkg::ROOF_STOP : bmc_pkg::ROOF_BACK;
            chg = 1'b1;
          end
        end
        bmc_pkg::PagePumpDuty: begin
          if (fire_up_i) begin
            tmp = bmc_pkg::duty_up(pduty_d, duty_step_i);
            chg = chg | (tmp != pduty_d);
            pduty_d = tmp;
          end
          if (fire_down_i) begin
            tmp = bmc_pkg::duty_down(pduty_d, duty_step_i);
            chg = chg | (tmp != pduty_d);
            pduty_d = tmp;
          end
        end
        bmc_pkg::PageRoofDuty: begin
          if (fire_up_i) begin
            tmp = bmc_pkg::duty_up(rduty_d, duty_step_i);
            chg = chg | (tmp != rduty_d);
            rduty_d = tmp;
          end
          if (fire_down_i) begin
            tmp = bmc_pkg::duty_down(rduty_d, duty_step_i);
            chg = chg | (tmp != rduty_d);
            rduty_d = tmp;
          end
        end
        default: begin
        end
      endcase
    end
    res_o.page = page_d;
    res_o.auto_mode = mode_d;
    res_o.pump_on = pump_d;
    res_o.roof = roof_d;
    res_o.pump_duty = pduty_d;
    res_o.roof_duty = rduty_d;
    res_o.changed = chg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= 3'd0;
      mode_q <= 1'b0;
      pump_q <= 1'b0;
      roof_q <= bmc_pkg::ROOF_STOP;
      pduty_q <= 7'd0;
      rduty_q <= 7'd0;
    end else if (upd_i) begin
      page_q <= page_d;
      mode_q <= mode_d;
      pump_q <= pump_d;
      roof_q <= roof_d;
      pduty_q <= pduty_d;
      rduty_q <= rduty_d;
    end
  end

`ifndef SYNTHESIS
  a_page_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_q <= bmc_pkg::PageLast) else $error("page out of range");
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pduty_q <= bmc_pkg::DutyMax && rduty_q <= bmc_pkg::DutyMax) else $error("duty above limit");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(page_q) && $stable(mode_q) && $stable(pduty_q))
    else $error("settings moved without a request");
`endif

endmodule

/* rtl/core/bmc_cfg.sv */
// bmc_cfg: APB-style configuration registers (debounce, hold, duty step)
// depends on bmc_pkg
module bmc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bmc_pkg::AddrW-1:0]  paddr,
  input  logic [bmc_pkg::DataW-1:0]  pwdata,
  output logic [bmc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output bmc_pkg::cfg_t              cfg_o
);

  bmc_pkg::cfg_t cfg_q, cfg_d;
  bmc_pkg::reg_e sel;
  logic          wr;

  assign sel = bmc_pkg::reg_e'(paddr[3:2]);
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    prdata = '0;
    unique case (sel)
      bmc_pkg::REG_DEBOUNCE: begin
        prdata = {16'd0, cfg_q.debounce_ms};
        if (wr) begin
          cfg_d.debounce_ms = pwdata[15:0];
        end
      end
      bmc_pkg::REG_HOLD: begin
        prdata = {16'd0, cfg_q.hold_ms};
        if (wr) begin
          cfg_d.hold_ms = pwdata[15:0];
        end
      end
      bmc_pkg::REG_STEP: begin
        prdata = {25'd0, cfg_q.duty_step};
        if (wr) begin
          cfg_d.duty_step = pwdata[6:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= bmc_pkg::DebounceRst;
      cfg_q.hold_ms <= bmc_pkg::HoldRst;
      cfg_q.duty_step <= bmc_pkg::DutyStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/core/button_menu_controller_top.sv */
// button_menu_controller_top: scan input register, debouncers, menu logic, result register
// depends on bmc_pkg, bmc_cfg, bmc_debounce, bmc_menu
//
// One scan (time stamp plus three active-low button levels) is taken per request and
// gives exactly one result. A scan is held in an input register, evaluated combinationally
// by the three debouncers and the menu logic, and its result is placed in an output
// register, which takes it only while the output is not stalled; a new scan is taken
// every cycle while results are being collected. The debounce, hold and duty step
// registers sit at byte addresses 0, 4 and 8 and should only be written while no scan
// is in flight.
module button_menu_controller_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [31:0]               now_ms_i,
  input  logic                      next_level_i,
  input  logic                      up_level_i,
  input  logic                      down_level_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                page_now_o,
  output logic                      auto_mode_o,
  output logic                      pump_on_o,
  output logic [1:0]                roof_motion_o,
  output logic [6:0]                pump_duty_out_o,
  output logic [6:0]                roof_duty_out_o,
  output logic                      changed_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bmc_pkg::AddrW-1:0] paddr,
  input  logic [bmc_pkg::DataW-1:0] pwdata,
  output logic [bmc_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  bmc_pkg::cfg_t cfg;
  bmc_pkg::res_t res_next, res_q;

  logic        s1_valid_q;
  logic [31:0] now_q;
  logic        next_q, up_q, down_q;
  logic        out_valid_q;
  logic        adv;
  logic        eval_ud;
  logic        fire_next, fire_up, fire_down;

  assign adv = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  bmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bmc_debounce u_db_next (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (adv),
    .eval_i  (1'b1),
    .level_i (next_q),
    .now_i   (now_q),
    .cfg_i   (cfg),
    .fire_o  (fire_next)
  );

  bmc_debounce u_db_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (adv),
    .eval_i  (eval_ud),
    .level_i (up_q),
    .now_i   (now_q),
    .cfg_i   (cfg),
    .fire_o  (fire_up)
  );

  bmc_debounce u_db_down (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (adv),
    .eval_i  (eval_ud),
    .level_i (down_q),
    .now_i   (now_q),
    .cfg_i   (cfg),
    .fire_o  (fire_down)
  );

  bmc_menu u_menu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (adv),
    .fire_next_i (fire_next),
    .fire_up_i   (fire_up),
    .fire_down_i (fire_down),
    .duty_step_i (cfg.duty_step),
    .eval_ud_o   (eval_ud),
    .res_o       (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q <= now_ms_i;
      next_q <= next_level_i;
      up_q <= up_level_i;
      down_q <= down_level_i;
    end
    if (adv) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign page_now_o = res_q.page;
  assign auto_mode_o = res_q.auto_mode;
  assign pump_on_o = res_q.pump_on;
  assign roof_motion_o = res_q.roof;
  assign pump_duty_out_o = res_q.pump_duty;
  assign roof_duty_out_o = res_q.roof_duty;
  assign changed_o = res_q.changed;

`ifndef SYNTHESIS
  a_scan_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q) else $error("scan dropped while stalled");
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q) else $error("result dropped while stalled");
  a_page_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> page_now_o <= bmc_pkg::PageLast) else $error("result page out of range");
  a_roof_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> roof_motion_o != 2'd3) else $error("bad roof motion code");
`endif

endmodule
